[hdl/slfp_pkg.sv]
// ----------------------------------------------------------------------------
// slfp_pkg: shared types and constants for the sync/length frame parser
// Phase codes, event kinds, register indexes and the event record format.
// ----------------------------------------------------------------------------
package slfp_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 32;
  localparam int REPORT_WIDTH        = 32;
  localparam int CFG_INDEX_WIDTH     = 2;
  localparam int CFG_DATA_WIDTH      = 16;

  localparam logic [15:0] SYNC_WORD_RESET     = 16'hA55A;
  localparam logic [15:0] PAYLOAD_LIMIT_RESET = 16'd1024;

  typedef enum logic [2:0] {
    PH_SYNC_LO = 3'd0,
    PH_SYNC_HI = 3'd1,
    PH_PORT_LO = 3'd2,
    PH_PORT_HI = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_LEN_HI  = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_EMPTY   = 2'd1,
    EV_ERROR   = 2'd2
  } event_kind_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_SYNC_WORD     = 2'd0,
    CFG_PAYLOAD_LIMIT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    event_kind_t             kind;
    logic [15:0]             port;
    logic [15:0]             length;
    logic [7:0]              data;
    logic                    last;
    logic [REPORT_WIDTH-1:0] records;
    logic [REPORT_WIDTH-1:0] errors;
  } event_t;

endpackage

[hdl/sync_length_frame_parser.sv]
// ----------------------------------------------------------------------------
// sync_length_frame_parser: sync word / port / length frame parser
// Parses a byte stream into payload, empty-record and framing-error events.
// ----------------------------------------------------------------------------
//  channel  signals                              direction
//  in       in_valid, in_ready, in_byte          byte stream in
//  out      out_valid, out_ready, event fields   one event per request
//  cfg      cfg_write, cfg_index, cfg_data       register writes, no wait
//
//  One byte per cycle while in_ready is high; a byte's event is registered.
//  The parse state and counters update in the same cycle the byte is taken.
//  Output register plus one skid entry: bytes keep flowing for one stalled
//  event, then in_ready drops until the sink takes one.
//  Synchronous reset restores the register defaults and clears all counters.
// ----------------------------------------------------------------------------
module sync_length_frame_parser #(
  parameter int COUNT_WIDTH = slfp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [slfp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [slfp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           event_kind,
  output logic [15:0]                          record_port,
  output logic [15:0]                          record_length,
  output logic [7:0]                           payload_byte,
  output logic                                 last_of_record,
  output logic [slfp_pkg::REPORT_WIDTH-1:0]    records_seen,
  output logic [slfp_pkg::REPORT_WIDTH-1:0]    errors_seen
);
  import slfp_pkg::*;

  logic   step;
  logic   ev_valid;
  event_t ev;
  event_t out_ev;

  assign step = in_valid && in_ready;

  slfp_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .in_byte   (in_byte),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  slfp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .load      (step && ev_valid),
    .load_data (ev),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_ev)
  );

  assign event_kind     = out_ev.kind;
  assign record_port    = out_ev.port;
  assign record_length  = out_ev.length;
  assign payload_byte   = out_ev.data;
  assign last_of_record = out_ev.last;
  assign records_seen   = out_ev.records;
  assign errors_seen    = out_ev.errors;

endmodule

[hdl/slfp_parser.sv]
// ----------------------------------------------------------------------------
// slfp_parser: frame parsing state and counters
// Updates the parse state on every accepted byte and builds the event record
// for bytes that produce one.
// ----------------------------------------------------------------------------
module slfp_parser #(
  parameter int COUNT_WIDTH = slfp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [slfp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [slfp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                 step,
  input  logic [7:0]                           in_byte,
  output logic                                 ev_valid,
  output slfp_pkg::event_t                     ev
);
  import slfp_pkg::*;

  logic [15:0]            sync_word;
  logic [15:0]            payload_limit;
  phase_t                 phase, phase_next;
  logic [15:0]            port_reg, port_reg_next;
  logic [15:0]            length_reg, length_reg_next;
  logic [15:0]            byte_offset, byte_offset_next;
  logic [COUNT_WIDTH-1:0] record_counter, record_counter_next;
  logic [COUNT_WIDTH-1:0] error_counter, error_counter_next;

  logic [7:0]  sync_lo;
  logic [7:0]  sync_hi;
  logic [15:0] len_full;
  logic [15:0] offset_inc;

  assign sync_lo    = sync_word[7:0];
  assign sync_hi    = sync_word[15:8];
  assign len_full   = {in_byte, length_reg[7:0]};
  assign offset_inc = byte_offset + 16'd1;

  always_comb begin
    phase_next          = phase;
    port_reg_next       = port_reg;
    length_reg_next     = length_reg;
    byte_offset_next    = byte_offset;
    record_counter_next = record_counter;
    error_counter_next  = error_counter;
    ev_valid            = 1'b0;
    ev.kind             = EV_PAYLOAD;
    ev.port             = port_reg;
    ev.length           = length_reg;
    ev.data             = 8'd0;
    ev.last             = 1'b0;

    unique case (phase)
      PH_SYNC_HI: begin
        // high-byte match wins over the repeated-low-byte rule
        if (in_byte == sync_hi) begin
          phase_next = PH_PORT_LO;
        end else if (in_byte == sync_lo) begin
          phase_next = PH_SYNC_HI;
        end else begin
          phase_next = PH_SYNC_LO;
        end
      end
      PH_PORT_LO: begin
        port_reg_next = {8'd0, in_byte};
        phase_next    = PH_PORT_HI;
      end
      PH_PORT_HI: begin
        port_reg_next = {in_byte, port_reg[7:0]};
        phase_next    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_reg_next = {8'd0, in_byte};
        phase_next      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        ev.length = len_full;
        if (len_full > payload_limit) begin
          error_counter_next = error_counter + COUNT_WIDTH'(1);
          ev_valid           = 1'b1;
          ev.kind            = EV_ERROR;
          phase_next         = PH_SYNC_LO;
          port_reg_next      = 16'd0;
          length_reg_next    = 16'd0;
          byte_offset_next   = 16'd0;
        end else if (len_full == 16'd0) begin
          record_counter_next = record_counter + COUNT_WIDTH'(1);
          ev_valid            = 1'b1;
          ev.kind             = EV_EMPTY;
          ev.last             = 1'b1;
          phase_next          = PH_SYNC_LO;
          port_reg_next       = 16'd0;
          length_reg_next     = 16'd0;
          byte_offset_next    = 16'd0;
        end else begin
          length_reg_next  = len_full;
          byte_offset_next = 16'd0;
          phase_next       = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        ev_valid = 1'b1;
        ev.kind  = EV_PAYLOAD;
        ev.data  = in_byte;
        if (offset_inc == length_reg) begin
          record_counter_next = record_counter + COUNT_WIDTH'(1);
          ev.last             = 1'b1;
          phase_next          = PH_SYNC_LO;
          port_reg_next       = 16'd0;
          length_reg_next     = 16'd0;
          byte_offset_next    = 16'd0;
        end else begin
          byte_offset_next = offset_inc;
        end
      end
      default: begin
        // sync low hunt; the unused code lands here too
        phase_next = (in_byte == sync_lo) ? PH_SYNC_HI : PH_SYNC_LO;
      end
    endcase

    ev.records = REPORT_WIDTH'(record_counter_next);
    ev.errors  = REPORT_WIDTH'(error_counter_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC_LO;
      port_reg       <= 16'd0;
      length_reg     <= 16'd0;
      byte_offset    <= 16'd0;
      record_counter <= '0;
      error_counter  <= '0;
    end else if (step) begin
      phase          <= phase_next;
      port_reg       <= port_reg_next;
      length_reg     <= length_reg_next;
      byte_offset    <= byte_offset_next;
      record_counter <= record_counter_next;
      error_counter  <= error_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word     <= SYNC_WORD_RESET;
      payload_limit <= PAYLOAD_LIMIT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_SYNC_WORD) begin
        sync_word <= cfg_data;
      end else if (cfg_index == CFG_PAYLOAD_LIMIT) begin
        payload_limit <= cfg_data;
      end
    end
  end

  a_offset_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> byte_offset < length_reg)
    else $error("payload offset reached frame length");

  a_error_restarts: assert property (@(posedge clk) disable iff (rst)
    step && ev_valid && ev.kind == EV_ERROR |=> phase == PH_SYNC_LO && length_reg == 16'd0)
    else $error("framing error did not restart the hunt");

  a_error_count_only_on_error: assert property (@(posedge clk) disable iff (rst)
    step && !(ev_valid && ev.kind == EV_ERROR) |=> $stable(error_counter))
    else $error("error counter moved without a framing error");

endmodule

[hdl/slfp_skid.sv]
// ----------------------------------------------------------------------------
// slfp_skid: event output register with one skid entry
// Holds the presented event and parks one more while the sink stalls.
// ----------------------------------------------------------------------------
module slfp_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  slfp_pkg::event_t load_data,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output slfp_pkg::event_t out_data
);
  import slfp_pkg::*;

  logic   skid_valid, skid_valid_next;
  logic   out_valid_next;
  event_t skid_data;
  logic   out_fire;
  logic   out_open;

  assign in_ready = !skid_valid;
  assign out_fire = out_valid && out_ready;
  assign out_open = !out_valid || out_ready;

  always_comb begin
    out_valid_next  = out_valid;
    skid_valid_next = skid_valid;
    if (skid_valid) begin
      if (out_fire) begin
        skid_valid_next = 1'b0;
        out_valid_next  = 1'b1;
      end
    end else if (load) begin
      if (out_open) begin
        out_valid_next = 1'b1;
      end else begin
        skid_valid_next = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (load) begin
      if (out_open) begin
        out_data <= load_data;
      end else begin
        skid_data <= load_data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_stall_parks: assert property (@(posedge clk) disable iff (rst)
    load && out_valid && !out_ready |=> skid_valid)
    else $error("event lost during output stall");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !load)
    else $error("event loaded while skid entry full");

endmodule

[bench/sync_length_frame_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_length_frame_parser_tb: self-checking bench for the frame parser
// Drives byte streams of framed and broken traffic under varying idle and
// stall profiles, predicts each event and compares it field by field.
// ----------------------------------------------------------------------------
module sync_length_frame_parser_tb;
  import slfp_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 4;
  localparam int REPORT_MAX   = 10;

  // indexes past the two mapped registers; writes there must be dropped
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNMAPPED_B = 2'd3;

  typedef logic [7:0] byte_seq_t[$];

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic [7:0]                 in_byte   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [1:0]                 event_kind;
  logic [15:0]                record_port;
  logic [15:0]                record_length;
  logic [7:0]                 payload_byte;
  logic                       last_of_record;
  logic [REPORT_WIDTH-1:0]    records_seen;
  logic [REPORT_WIDTH-1:0]    errors_seen;

  // parser prediction state
  phase_t                  ph        = PH_SYNC_LO;
  logic [15:0]             cur_port  = '0;
  logic [15:0]             cur_len   = '0;
  logic [15:0]             pay_count = '0;
  logic [REPORT_WIDTH-1:0] rec_total = '0;
  logic [REPORT_WIDTH-1:0] err_total = '0;
  logic [15:0]             sync_cfg  = SYNC_WORD_RESET;
  logic [15:0]             limit_cfg = PAYLOAD_LIMIT_RESET;

  event_t events_due[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_go       = 1'b0;
  int stall_left    = 0;
  int quiet_cycles  = 0;
  int fail_count    = 0;
  int bytes_sent    = 0;
  int payload_seen  = 0;
  int empty_seen    = 0;
  int error_seen    = 0;
  int settings_used = 0;

  sync_length_frame_parser dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .record_port    (record_port),
    .record_length  (record_length),
    .payload_byte   (payload_byte),
    .last_of_record (last_of_record),
    .records_seen   (records_seen),
    .errors_seen    (errors_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  task automatic push_event(input event_kind_t kind, input logic [7:0] data,
                            input logic last);
    event_t ev;
    ev.kind    = kind;
    ev.port    = cur_port;
    ev.length  = cur_len;
    ev.data    = data;
    ev.last    = last;
    ev.records = rec_total;
    ev.errors  = err_total;
    events_due.push_back(ev);
  endtask

  task automatic restart_hunt();
    ph        = PH_SYNC_LO;
    cur_port  = '0;
    cur_len   = '0;
    pay_count = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    case (ph)
      PH_SYNC_HI: begin
        // high-byte match wins even when both sync bytes are equal
        if (b == sync_cfg[15:8]) ph = PH_PORT_LO;
        else if (b == sync_cfg[7:0]) ph = PH_SYNC_HI;
        else ph = PH_SYNC_LO;
      end
      PH_PORT_LO: begin
        cur_port = {8'h00, b};
        ph = PH_PORT_HI;
      end
      PH_PORT_HI: begin
        cur_port[15:8] = b;
        ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        cur_len = {8'h00, b};
        ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        cur_len[15:8] = b;
        if (cur_len > limit_cfg) begin
          err_total = err_total + 1'b1;
          push_event(EV_ERROR, 8'h00, 1'b0);
          restart_hunt();
        end else if (cur_len == 16'd0) begin
          rec_total = rec_total + 1'b1;
          push_event(EV_EMPTY, 8'h00, 1'b1);
          restart_hunt();
        end else begin
          pay_count = '0;
          ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pay_count = pay_count + 1'b1;
        if (pay_count == cur_len) begin
          rec_total = rec_total + 1'b1;
          push_event(EV_PAYLOAD, b, 1'b1);
          restart_hunt();
        end else begin
          push_event(EV_PAYLOAD, b, 1'b0);
        end
      end
      default: ph = (b == sync_cfg[7:0]) ? PH_SYNC_HI : PH_SYNC_LO;
    endcase
  endtask

  // ---------------------------------------------------------------- checking
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("mismatch: %s", msg);
  endtask

  task automatic check_event();
    event_t want;
    bit     bad;
    if (events_due.size() == 0) begin
      note_failure($sformatf("unexpected event kind=%0d port=%h len=%h data=%h",
                             event_kind, record_port, record_length, payload_byte));
      return;
    end
    want = events_due.pop_front();
    bad = (event_kind !== want.kind) || (record_port !== want.port) ||
          (record_length !== want.length) || (payload_byte !== want.data) ||
          (last_of_record !== want.last) || (records_seen !== want.records) ||
          (errors_seen !== want.errors);
    if (bad)
      note_failure($sformatf({
        "exp kind=%0d port=%h len=%h data=%h last=%b rec=%0d err=%0d / ",
        "got kind=%0d port=%h len=%h data=%h last=%b rec=%0d err=%0d"},
        want.kind, want.port, want.length, want.data, want.last, want.records,
        want.errors, event_kind, record_port, record_length, payload_byte,
        last_of_record, records_seen, errors_seen));
    case (event_kind)
      EV_PAYLOAD: payload_seen++;
      EV_EMPTY:   empty_seen++;
      default:    error_seen++;
    endcase
  endtask

  // output check first: an event can never leave on the edge its byte enters
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_event();
      if (in_valid && in_ready) parse_byte(in_byte);
    end
  end

  // ---------------------------------------------------------------- sink side
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_go) begin
        stall_left = HOLD_CYCLES;
        hold_go = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no request accepted for %0d cycles, %0d events pending",
               QUIET_LIMIT, events_due.size());
      $display("sync_length_frame_parser_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_seq(input byte_seq_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic send_frame(input logic [15:0] port, input logic [15:0] len);
    send_byte(sync_cfg[7:0]);
    send_byte(sync_cfg[15:8]);
    send_byte(port[7:0]);
    send_byte(port[15:8]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (len != 16'd0 && len <= limit_cfg)
      repeat (len) send_byte(8'($urandom_range(255)));
  endtask

  // hold input off until every predicted event is out, plus pipeline slack;
  // an edge first so the last accepted byte is already in the prediction
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_SYNC_WORD) sync_cfg = data;
    else if (idx == CFG_PAYLOAD_LIMIT) limit_cfg = data;
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_default_frames();
    // repeated low sync byte, all-ones port, one-byte record
    send_seq('{8'h5A, 8'h5A, 8'hA5, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'hFF});
    // empty record, all-zero fields
    send_seq('{8'h5A, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h00});
    drain();
  endtask

  task automatic test_midframe_writes();
    send_byte(8'h5A);
    drain();
    write_reg(CFG_SYNC_WORD, 16'h3C3C);
    send_seq('{8'h3C, 8'h34, 8'h12, 8'h05});
    drain();
    // limit lowered between the length bytes: length 5 is now too long
    write_reg(CFG_PAYLOAD_LIMIT, 16'd4);
    send_byte(8'h00);
    drain();
  endtask

  task automatic test_equal_sync_bytes();
    send_seq('{8'h3C, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h00});
    drain();
    settings_used++;
  endtask

  task automatic test_output_backpressure();
    write_reg(CFG_PAYLOAD_LIMIT, 16'd64);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_go       = 1'b1;
    send_frame(16'hBEEF, 16'd40);
    drain();
    settings_used++;
  endtask

  task automatic test_random_traffic(input int idle_s, input int idle_r,
                                     input logic [15:0] sync,
                                     input logic [15:0] limit, input int n_bytes);
    int          stop_at;
    int          span;
    int          r;
    logic [15:0] len;
    logic [7:0]  b;
    drain();
    write_reg(CFG_SYNC_WORD, sync);
    write_reg(CFG_PAYLOAD_LIMIT, limit);
    write_reg(CFG_UNMAPPED_A, 16'($urandom));
    write_reg(CFG_UNMAPPED_B, 16'($urandom));
    settings_used++;
    send_idle_pct = idle_s;
    stall_pct     = idle_r;
    stop_at       = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 10) begin
        // line noise that can never open a frame
        repeat ($urandom_range(1, 4)) begin
          do b = 8'($urandom_range(255)); while (b == sync_cfg[7:0]);
          send_byte(b);
        end
      end else if (r < 18) begin
        // low sync byte followed by garbage drops back to hunting
        send_byte(sync_cfg[7:0]);
        do b = 8'($urandom_range(255));
        while (b == sync_cfg[7:0] || b == sync_cfg[15:8]);
        send_byte(b);
      end else begin
        if (sync_cfg[7:0] != sync_cfg[15:8] && $urandom_range(3) == 0)
          repeat ($urandom_range(1, 3)) send_byte(sync_cfg[7:0]);
        r = $urandom_range(99);
        if (r < 12) begin
          len = 16'd0;
        end else if (r < 26 && limit_cfg != 16'hFFFF) begin
          span = 65534 - int'(limit_cfg);
          len = limit_cfg + 16'd1 + 16'($urandom_range(span));
        end else if (r < 36 && limit_cfg != 16'd0 && limit_cfg <= 16'd16) begin
          len = limit_cfg;
        end else if (limit_cfg == 16'd0) begin
          len = 16'($urandom_range(1, 8));
        end else begin
          len = 16'($urandom_range(1, (limit_cfg < 16'd8) ? int'(limit_cfg) : 8));
        end
        send_frame(16'($urandom), len);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_frames();
    test_midframe_writes();
    test_equal_sync_bytes();
    test_output_backpressure();
    test_random_traffic(0, 0, 16'h0000, 16'd0, 140);
    test_random_traffic(71, 0, 16'hFFFF, 16'hFFFF, 140);
    test_random_traffic(0, 71, 16'($urandom), 16'($urandom_range(1, 12)), 140);
    test_random_traffic(23, 23, 16'($urandom), 16'($urandom), 140);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d bytes in, %0d events out: %0d payload, %0d empty, %0d framing errors",
             bytes_sent, payload_seen + empty_seen + error_seen, payload_seen,
             empty_seen, error_seen);
    $display("across %0d register settings and four idle/stall profiles, %0d failures",
             settings_used, fail_count);
    if (fail_count == 0)
      $display("sync_length_frame_parser_tb: PASS");
    else
      $display("sync_length_frame_parser_tb: FAIL");
    $finish;
  end

endmodule
